/* hw/rtl/fenwick_range_sum_table_unit_defines.svh */
// Assertion macros for the Fenwick range-sum table unit.
// Used by the top level only; no other dependencies.
`ifndef FENWICK_RANGE_SUM_TABLE_UNIT_DEFINES_SVH
`define FENWICK_RANGE_SUM_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FWRS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FWRS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fwrs_pkg.sv */
// Shared widths, codes, structs and helpers of the Fenwick range-sum table.
// No dependencies; the interfaces, the sequencer and the top level use it.
package fwrs_pkg;

  localparam int unsigned IDX_W     = 11;
  localparam int unsigned POS_W     = IDX_W + 1;  // walk positions up to 2*size
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned MAX_IDX   = (1 << IDX_W) - 1;

  localparam logic [IDX_W-1:0] SIZE_RST = IDX_W'(1024);

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         index;
    logic [IDX_W-1:0]         right_index;
    logic signed [DATA_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } seq_stat_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] sum;
    logic                     error;
  } seq_res_t;

  function automatic logic [POS_W-1:0] lowbit(input logic [POS_W-1:0] p);
    return p & (~p + POS_W'(1));
  endfunction

endpackage

/* hw/rtl/fwrs_in_if.sv */
// Input channel of the Fenwick range-sum table: valid/ready plus command item.
// Depends on fwrs_pkg.
interface fwrs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [fwrs_pkg::IDX_W-1:0]         index;
  logic [fwrs_pkg::IDX_W-1:0]         right_index;
  logic signed [fwrs_pkg::DATA_W-1:0] delta;

  modport source (output valid, cmd, index, right_index, delta, input ready);
  modport sink   (input valid, cmd, index, right_index, delta, output ready);
endinterface

/* hw/rtl/fwrs_out_if.sv */
// Result channel of the Fenwick range-sum table: valid/ready plus sum and error.
// Depends on fwrs_pkg.
interface fwrs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fwrs_pkg::DATA_W-1:0] sum;
  logic                               error;

  modport source (output valid, sum, error, input ready);
  modport sink   (input valid, sum, error, output ready);
endinterface

/* hw/rtl/fwrs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fwrs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/fwrs_seq.sv */
// Walk sequencer of the Fenwick range-sum table: clearing pass, update walk,
// two prefix walks per query. Holds the tree RAM. Depends on fwrs_pkg, fwrs_ram.
module fwrs_seq #(
  parameter int unsigned DEPTH = fwrs_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fwrs_pkg::IDX_W-1:0] size,
  input  fwrs_pkg::item_t            item,
  input  logic                       item_valid,
  input  logic                       out_free,
  output fwrs_pkg::seq_stat_t        stat,
  output fwrs_pkg::seq_res_t         res
);
  import fwrs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_UP   = 5'b00100,
    S_QRY  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    low_r, low_nxt;
  logic                neg_r, neg_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_neg_r, pend_neg_nxt;
  logic [POS_W-1:0]    pend_pos_r, pend_pos_nxt;
  logic [DATA_W-1:0]   delta_r, delta_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                err_r, err_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_W-1:0]   wdata;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;

  logic [POS_W-1:0]    size_pos;
  logic [POS_W-1:0]    left_pos;
  logic [POS_W-1:0]    low_raw;

  // position p lives at address p-1
  function automatic logic [AW-1:0] pos2addr(input logic [POS_W-1:0] p);
    return AW'(p - POS_W'(1));
  endfunction

  fwrs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign size_pos = {1'b0, size};
  assign left_pos = {1'b0, item.index};
  assign low_raw  = (left_pos == '0) ? '0 : left_pos - POS_W'(1);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    low_nxt      = low_r;
    neg_nxt      = neg_r;
    pend_nxt     = pend_r;
    pend_neg_nxt = pend_neg_r;
    pend_pos_nxt = pend_pos_r;
    delta_nxt    = delta_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    clr_cnt_nxt  = clr_cnt_r;
    we           = 1'b0;
    waddr        = pos2addr(pend_pos_r);
    wdata        = rdata + delta_r;
    raddr        = pos2addr(pos_r);
    res.done     = 1'b0;
    res.sum      = acc_r;
    res.error    = err_r;

    case (state_r)
      S_CLR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          delta_nxt = item.delta;
          acc_nxt   = '0;
          err_nxt   = 1'b0;
          pend_nxt  = 1'b0;
          neg_nxt   = 1'b0;
          if (item.cmd == CMD_ADD) begin
            if (item.index == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              pos_nxt   = left_pos;
              state_nxt = S_UP;
            end
          end else begin
            if (item.right_index > size) begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              pos_nxt   = {1'b0, item.right_index};
              low_nxt   = (low_raw > size_pos) ? size_pos : low_raw;
              state_nxt = S_QRY;
            end
          end
        end
      end
      S_UP: begin
        // write back the entry read last cycle while reading the next one;
        // upward positions never repeat, so no forwarding is needed
        we = pend_r;
        if (pos_r <= size_pos) begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = pos_r;
          pos_nxt      = pos_r + lowbit(pos_r);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_QRY: begin
        if (pend_r) begin
          acc_nxt = pend_neg_r ? acc_r - rdata : acc_r + rdata;
        end
        if (pos_r != '0) begin
          pend_nxt     = 1'b1;
          pend_neg_nxt = neg_r;
          pos_nxt      = pos_r - lowbit(pos_r);
        end else if (!neg_r) begin
          // right prefix done, start the subtracted lower prefix
          pend_nxt = 1'b0;
          neg_nxt  = 1'b1;
          pos_nxt  = low_r;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        res.done = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    low_r      <= low_nxt;
    neg_r      <= neg_nxt;
    pend_neg_r <= pend_neg_nxt;
    pend_pos_r <= pend_pos_nxt;
    delta_r    <= delta_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
  end

  assign stat.ready    = (state_r == S_IDLE);
  assign stat.clearing = (state_r == S_CLR);

endmodule

/* hw/rtl/fenwick_range_sum_table_unit.sv */
// Fenwick range-sum table. Update: one RAM access per tree level (read of the next
// entry overlaps write-back of the last). Query: a walk adding the right prefix,
// then one subtracting the lower prefix. Errors and ignored updates skip the walk.
// One item at a time: the next item is taken only after the result is registered
// and the sequencer is back in idle. Reset (sync, rst_n low): size = 1024, then a
// clearing pass zeroes every entry, no accept until done.
`include "fenwick_range_sum_table_unit_defines.svh"

module fenwick_range_sum_table_unit #(
  parameter int unsigned DEPTH = fwrs_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fwrs_in_if.sink                    in_ch,
  fwrs_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [fwrs_pkg::IDX_W-1:0] cfg_wdata
);
  import fwrs_pkg::*;

  // largest size the index fields can name within this depth
  localparam int unsigned DCAP = (DEPTH > MAX_IDX) ? MAX_IDX : DEPTH;

  logic [IDX_W-1:0]  size_r;
  logic [IDX_W-1:0]  eff_size;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_r;
  logic              out_err_r;
  logic              out_free;
  item_t             item;
  seq_stat_t         stat;
  seq_res_t          res;

  // size register; the effective size saturates at the table depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  assign eff_size = (size_r > IDX_W'(DCAP)) ? IDX_W'(DCAP) : size_r;

  assign item.cmd         = in_ch.cmd;
  assign item.index       = in_ch.index;
  assign item.right_index = in_ch.right_index;
  assign item.delta       = in_ch.delta;

  // output register frees a slot as soon as the sink takes the item
  assign out_free = !out_valid_r || out_ch.ready;

  fwrs_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .size       (eff_size),
    .item       (item),
    .item_valid (in_ch.valid),
    .out_free   (out_free),
    .stat       (stat),
    .res        (res)
  );

  assign in_ch.ready = stat.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_sum_r <= res.sum;
      out_err_r <= res.error;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sum   = out_sum_r;
  assign out_ch.error = out_err_r;

  // no item taken while the table is being cleared
  `FWRS_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, stat.clearing, !in_ch.ready,
                   "item ready during clearing pass")
  // a finished result never overwrites one still waiting
  `FWRS_ASSERT_IMP(a_no_overwrite, clk, rst_n, res.done, out_free,
                   "result overwrote pending output")
  // an error result carries a zero sum
  `FWRS_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && out_err_r, out_sum_r == '0,
                   "error result with nonzero sum")
  // one item at a time: ready drops right after an accept
  `FWRS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready,
                   !in_ch.ready, "ready held after accept")

endmodule
